// ===== hw/rtl/abchk_pkg.sv =====
// abchk_pkg: types, constants and crc helper for the a/b slot record checker
// used by the front, back, fifo and top level modules
package abchk_pkg;

    localparam int SlotBytesDefault = 256;
    localparam logic [31:0] CrcPoly = 32'hedb88320;
    localparam logic [31:0] CrcInit = 32'hffffffff;
    localparam logic [31:0] SerialHalf = 32'h80000000;
    localparam logic [15:0] HdrLen = 16'd12;
    localparam logic [7:0] MaxLenReset = 8'd240;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_FAIL = 2'd1;
    localparam logic [1:0] CMD_SELECT = 2'd2;
    localparam logic [1:0] CMD_COMMIT = 2'd3;

    localparam logic [1:0] KIND_SLOT = 2'd0;
    localparam logic [1:0] KIND_LOAD = 2'd1;
    localparam logic [1:0] KIND_COMMIT = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_IO_ERROR = 2'd2;
    localparam logic [1:0] ST_NOT_SCANNED = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic       slot;
        logic [7:0] data_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic        slot_id;
        logic        slot_valid;
        logic        slot_tombstone;
        logic [31:0] generation;
        logic [1:0]  load_status;
        logic        has_active;
        logic        write_target;
        logic [31:0] write_generation;
    } t_out;

    // classified transaction between front and back
    typedef struct packed {
        logic [1:0]  cmd;
        logic        slot;
        logic        valid;
        logic        tombstone;
        logic [31:0] generation;
    } t_op;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/ab_slot_record_checker_unit.sv =====
// ab_slot_record_checker_unit: top level of the a/b slot record checker
// depends on abchk_pkg, abchk_front, abchk_back, abchk_fifo
//
// input channel: push/full queue of t_in transactions (slot byte, read failure,
// select, commit); one transaction is taken per cycle while full is low
// result channel: empty/pop queue of t_out transactions; a result passes the
// front stage register and then the result queue before it can be popped, a
// slot byte without last causes none
// configuration: i_cfg_we writes max_record_length from i_cfg_data, reset 240
// throughput is one transaction per cycle while full is low; the crc update of
// one byte is the longest path in the parser stage
// a four entry result queue lets the consumer stall; full rises once two
// results wait, leaving room for those still in flight
// reset is synchronous active low and clears the stream, slot verdicts,
// active slot and the result queue
module ab_slot_record_checker_unit #(
    parameter int SLOT_BYTES = abchk_pkg::SlotBytesDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  abchk_pkg::t_in    i_in,
    output logic              empty,
    input  logic              pop,
    output abchk_pkg::t_out   o_out,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data
);
    import abchk_pkg::*;

    logic [7:0] r_max_len;
    logic       acc, op_valid, res_valid;
    t_op        op;
    t_out       res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_len <= MaxLenReset;
        else if (i_cfg_we) r_max_len <= i_cfg_data;
    end

    assign acc = push && !full;

    abchk_front #(.SLOT_BYTES(SLOT_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(acc), .i_in(i_in),
        .i_max_len(r_max_len), .o_op_valid(op_valid), .o_op(op)
    );

    abchk_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op_valid(op_valid), .i_op(op),
        .o_res_valid(res_valid), .o_res(res)
    );

    abchk_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_valid), .i_data(res),
        .i_pop(pop), .o_almost_full(full), .o_empty(empty), .o_data(o_out)
    );

endmodule

// ===== hw/rtl/abchk_front.sv =====
// abchk_front: byte stream parser and crc check, emits classified transactions
// depends on abchk_pkg
module abchk_front #(
    parameter int SLOT_BYTES = abchk_pkg::SlotBytesDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  abchk_pkg::t_in    i_in,
    input  logic [7:0]        i_max_len,
    output logic              o_op_valid,
    output abchk_pkg::t_op    o_op
);
    import abchk_pkg::*;

    localparam logic [16:0] SlotLimit = 17'(SLOT_BYTES);

    logic [15:0] r_idx, n_idx;
    logic [31:0] r_crc, n_crc;
    logic        r_hok, n_hok;
    logic [15:0] r_len, n_len;
    logic [31:0] r_gen, n_gen;
    logic [31:0] r_scrc, n_scrc;
    logic        r_op_valid;
    t_op         r_op, n_op;

    logic [16:0] crc_end;
    logic [16:0] need;
    logic [16:0] off;
    logic        ok;
    logic [7:0]  b;

    always_comb begin
        b = i_in.data_byte;
        n_idx = r_idx;
        n_crc = r_crc;
        n_hok = r_hok;
        n_len = r_len;
        n_gen = r_gen;
        n_scrc = r_scrc;
        n_op = '0;
        n_op.cmd = i_in.cmd;
        n_op.slot = i_in.slot;
        ok = 1'b0;
        unique case (r_idx)
            16'd0: if (b != 8'h4f) n_hok = 1'b0;
            16'd1: if (b != 8'h48) n_hok = 1'b0;
            16'd2: if (b != 8'h43) n_hok = 1'b0;
            16'd3: if (b != 8'h53) n_hok = 1'b0;
            16'd4: if (b != 8'd1) n_hok = 1'b0;
            16'd5: if (b != 8'd0) n_hok = 1'b0;
            16'd6: n_len[7:0] = b;
            16'd7: n_len[15:8] = b;
            16'd8: n_gen[7:0] = b;
            16'd9: n_gen[15:8] = b;
            16'd10: n_gen[23:16] = b;
            16'd11: n_gen[31:24] = b;
            default: ;
        endcase
        crc_end = {1'b0, HdrLen} + {1'b0, n_len};
        off = {1'b0, r_idx} - crc_end;
        if (r_idx < HdrLen || {1'b0, r_idx} < crc_end) begin
            n_crc = crc_byte(r_crc, b);
        end else if ({1'b0, r_idx} < crc_end + 17'd4) begin
            case (off[1:0])
                2'd0: n_scrc[7:0] = b;
                2'd1: n_scrc[15:8] = b;
                2'd2: n_scrc[23:16] = b;
                default: n_scrc[31:24] = b;
            endcase
        end
        if (r_idx != 16'hffff) n_idx = r_idx + 16'd1;
        need = crc_end + 17'd4;
        ok = n_hok && ({1'b0, n_idx} >= need) && (need <= SlotLimit)
            && (n_len <= {8'd0, i_max_len}) && (n_scrc == ~n_crc);
        n_op.valid = ok;
        n_op.tombstone = ok && (n_len == 16'd0);
        n_op.generation = ok ? n_gen : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_crc <= CrcInit;
            r_hok <= 1'b1;
            r_len <= '0;
            r_gen <= '0;
            r_scrc <= '0;
            r_op_valid <= 1'b0;
        end else begin
            r_op_valid <= 1'b0;
            if (i_in_valid) begin
                r_op <= n_op;
                r_op_valid <= (i_in.cmd != CMD_BYTE) || i_in.last;
                if (i_in.cmd == CMD_FAIL || (i_in.cmd == CMD_BYTE && i_in.last)) begin
                    r_idx <= '0;
                    r_crc <= CrcInit;
                    r_hok <= 1'b1;
                    r_len <= '0;
                    r_gen <= '0;
                    r_scrc <= '0;
                end else if (i_in.cmd == CMD_BYTE) begin
                    r_idx <= n_idx;
                    r_crc <= n_crc;
                    r_hok <= n_hok;
                    r_len <= n_len;
                    r_gen <= n_gen;
                    r_scrc <= n_scrc;
                end
            end
        end
    end

    assign o_op_valid = r_op_valid;
    assign o_op = r_op;

endmodule

// ===== hw/rtl/abchk_back.sv =====
// abchk_back: slot verdict store, active slot selection and commit
// depends on abchk_pkg
module abchk_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_valid,
    input  abchk_pkg::t_op    i_op,
    output logic              o_res_valid,
    output abchk_pkg::t_out   o_res
);
    import abchk_pkg::*;

    logic [1:0]  r_valid, r_tomb, r_rok;
    logic [31:0] r_sgen [2];
    logic        r_scanned, r_present, r_aslot;
    logic [31:0] r_agen;

    logic [1:0]  n_valid, n_tomb, n_rok;
    logic [31:0] n_sgen [2];
    logic        n_scanned, n_present, n_aslot;
    logic [31:0] n_agen;
    t_out        res;
    logic        use_b, sel;
    logic [31:0] d;

    always_comb begin
        n_valid = r_valid;
        n_tomb = r_tomb;
        n_rok = r_rok;
        n_sgen = r_sgen;
        n_scanned = r_scanned;
        n_present = r_present;
        n_aslot = r_aslot;
        n_agen = r_agen;
        res = '0;
        d = r_sgen[1] - r_sgen[0];
        use_b = r_valid[1] && (!r_valid[0] || (d != 32'd0 && d < SerialHalf));
        sel = use_b;
        case (i_op.cmd)
            CMD_BYTE, CMD_FAIL: begin
                n_rok[i_op.slot] = (i_op.cmd == CMD_BYTE);
                n_valid[i_op.slot] = i_op.valid && (i_op.cmd == CMD_BYTE);
                n_tomb[i_op.slot] = i_op.tombstone && (i_op.cmd == CMD_BYTE);
                n_sgen[i_op.slot] = (i_op.cmd == CMD_BYTE) ? i_op.generation : 32'd0;
                res.kind = KIND_SLOT;
                res.slot_id = i_op.slot;
                res.slot_valid = n_valid[i_op.slot];
                res.slot_tombstone = n_tomb[i_op.slot];
                res.generation = n_sgen[i_op.slot];
            end
            CMD_SELECT: begin
                n_scanned = 1'b1;
                if (!r_valid[0] && !r_valid[1]) begin
                    n_present = 1'b0;
                    n_agen = '0;
                    res.load_status = (!r_rok[0] && !r_rok[1]) ? ST_IO_ERROR : ST_EMPTY;
                end else begin
                    n_aslot = sel;
                    n_agen = r_sgen[sel];
                    n_present = 1'b1;
                    res.load_status = r_tomb[sel] ? ST_EMPTY : ST_OK;
                end
                res.kind = KIND_LOAD;
            end
            default: begin
                if (r_scanned) begin
                    n_aslot = r_present && !r_aslot;
                    n_agen = r_present ? r_agen + 32'd1 : 32'd1;
                    n_present = 1'b1;
                    res.load_status = ST_OK;
                end else begin
                    res.load_status = ST_NOT_SCANNED;
                end
                res.kind = KIND_COMMIT;
            end
        endcase
        if (i_op.cmd == CMD_SELECT || i_op.cmd == CMD_COMMIT) begin
            res.slot_id = n_aslot;
            res.generation = n_agen;
        end
        res.has_active = n_present;
        res.write_target = n_present && !n_aslot;
        res.write_generation = n_present ? n_agen + 32'd1 : 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_tomb <= '0;
            r_rok <= '0;
            r_sgen[0] <= '0;
            r_sgen[1] <= '0;
            r_scanned <= 1'b0;
            r_present <= 1'b0;
            r_aslot <= 1'b0;
            r_agen <= '0;
        end else if (i_op_valid) begin
            r_valid <= n_valid;
            r_tomb <= n_tomb;
            r_rok <= n_rok;
            r_sgen <= n_sgen;
            r_scanned <= n_scanned;
            r_present <= n_present;
            r_aslot <= n_aslot;
            r_agen <= n_agen;
        end
    end

    assign o_res_valid = i_op_valid;
    assign o_res = res;

endmodule

// ===== hw/rtl/abchk_fifo.sv =====
// abchk_fifo: small result queue decoupling the checker from the consumer
// depends on abchk_pkg
module abchk_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  abchk_pkg::t_out   i_data,
    input  logic              i_pop,
    output logic              o_almost_full,
    output logic              o_empty,
    output abchk_pkg::t_out   o_data
);
    import abchk_pkg::*;

    localparam int Depth = 4;

    t_out       r_mem [Depth];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_pop;

    assign do_pop = i_pop && (r_cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (do_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, do_pop};
        end
    end

    // two slots kept free for the transaction that may already be in the front stage
    assign o_almost_full = r_cnt >= 3'd2;
    assign o_empty = r_cnt == 3'd0;
    assign o_data = r_mem[r_rp];

endmodule

// ===== bench/ab_slot_record_checker_unit_tb.sv =====
// ab_slot_record_checker_unit_tb: self-checking bench for the a/b slot record checker
// streams slot images, read failures, selects and commits; predicts results in-bench
// depends on abchk_pkg and ab_slot_record_checker_unit
module ab_slot_record_checker_unit_tb;
    import abchk_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SlotSize = 256;
    localparam int WatchLimit = 4000;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_in i_in;
    logic empty;
    logic pop;
    t_out o_out;
    logic i_cfg_we;
    logic [7:0] i_cfg_data;

    ab_slot_record_checker_unit #(.SLOT_BYTES(SlotSize)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in(i_in),
        .empty(empty), .pop(pop), .o_out(o_out), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [7:0] max_len;
    logic [15:0] byte_idx;
    logic [31:0] crc_acc;
    logic hdr_good;
    logic [15:0] rec_len;
    logic [31:0] hdr_gen;
    logic [31:0] crc_stored;
    logic [1:0] sl_valid, sl_tomb, sl_read;
    logic [31:0] sl_gen [2];
    logic scanned;
    logic act_present;
    logic act_slot;
    logic [31:0] act_gen;

    t_in pending_items[$];
    t_out expected_results[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int results_seen;
    int idle_count;
    logic in_taken;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) r = (r >> 1) ^ (32'hedb88320 & {32{r[0]}});
        return r;
    endfunction

    function automatic logic serial_newer(logic [31:0] cand, logic [31:0] ref_gen);
        logic [31:0] d;
        d = cand - ref_gen;
        return d != 32'd0 && d < 32'h80000000;
    endfunction

    task automatic clear_stream();
        byte_idx = '0;
        crc_acc = 32'hffffffff;
        hdr_good = 1'b1;
        rec_len = '0;
        hdr_gen = '0;
        crc_stored = '0;
    endtask

    task automatic reset_checker_model();
        max_len = 8'd240;
        clear_stream();
        sl_valid = '0;
        sl_tomb = '0;
        sl_read = '0;
        sl_gen[0] = '0;
        sl_gen[1] = '0;
        scanned = 1'b0;
        act_present = 1'b0;
        act_slot = 1'b0;
        act_gen = '0;
    endtask

    task automatic predict_checker(t_in it);
        t_out r;
        logic [31:0] idx, crc_end, need;
        logic ok, use_b;
        logic [7:0] magic [4];
        magic[0] = "O";
        magic[1] = "H";
        magic[2] = "C";
        magic[3] = "S";
        r = '0;
        if (it.cmd == CMD_BYTE) begin
            idx = {16'd0, byte_idx};
            if (idx < 4) begin
                if (it.data_byte != magic[idx[1:0]]) hdr_good = 1'b0;
            end else if (idx == 4) begin
                if (it.data_byte != 8'd1) hdr_good = 1'b0;
            end else if (idx == 5) begin
                if (it.data_byte != 8'd0) hdr_good = 1'b0;
            end else if (idx == 6) begin
                rec_len[7:0] = it.data_byte;
            end else if (idx == 7) begin
                rec_len[15:8] = it.data_byte;
            end else if (idx < 12) begin
                hdr_gen = hdr_gen | ({24'd0, it.data_byte} << (8 * (idx - 8)));
            end
            crc_end = 32'd12 + {16'd0, rec_len};
            if (idx < 12 || idx < crc_end) crc_acc = crc_step(crc_acc, it.data_byte);
            else if (idx < crc_end + 4)
                crc_stored = crc_stored | ({24'd0, it.data_byte} << (8 * (idx - crc_end)));
            if (byte_idx != 16'hffff) byte_idx = byte_idx + 16'd1;
            if (!it.last) return;
            need = crc_end + 32'd4;
            ok = hdr_good && {16'd0, byte_idx} >= need && need <= SlotSize &&
                 rec_len <= {8'd0, max_len} && crc_stored == ~crc_acc;
            sl_read[it.slot] = 1'b1;
            sl_valid[it.slot] = ok;
            sl_tomb[it.slot] = ok && rec_len == 16'd0;
            sl_gen[it.slot] = ok ? hdr_gen : 32'd0;
            clear_stream();
        end else if (it.cmd == CMD_FAIL) begin
            sl_read[it.slot] = 1'b0;
            sl_valid[it.slot] = 1'b0;
            sl_tomb[it.slot] = 1'b0;
            sl_gen[it.slot] = '0;
            clear_stream();
        end
        if (it.cmd == CMD_BYTE || it.cmd == CMD_FAIL) begin
            r.kind = KIND_SLOT;
            r.slot_id = it.slot;
            r.slot_valid = sl_valid[it.slot];
            r.slot_tombstone = sl_tomb[it.slot];
            r.generation = sl_gen[it.slot];
            r.load_status = ST_OK;
        end else if (it.cmd == CMD_SELECT) begin
            scanned = 1'b1;
            if (!sl_valid[0] && !sl_valid[1]) begin
                act_present = 1'b0;
                act_gen = '0;
                r.load_status = (!sl_read[0] && !sl_read[1]) ? ST_IO_ERROR : ST_EMPTY;
            end else begin
                use_b = sl_valid[1] && (!sl_valid[0] || serial_newer(sl_gen[1], sl_gen[0]));
                act_slot = use_b;
                act_gen = sl_gen[use_b];
                act_present = 1'b1;
                r.load_status = sl_tomb[use_b] ? ST_EMPTY : ST_OK;
            end
            r.kind = KIND_LOAD;
        end else begin
            if (scanned) begin
                act_slot = act_present && act_slot == 1'b0;
                act_gen = act_present ? act_gen + 32'd1 : 32'd1;
                act_present = 1'b1;
                r.load_status = ST_OK;
            end else begin
                r.load_status = ST_NOT_SCANNED;
            end
            r.kind = KIND_COMMIT;
        end
        if (it.cmd == CMD_SELECT || it.cmd == CMD_COMMIT) begin
            r.slot_id = act_slot;
            r.generation = act_gen;
        end
        r.has_active = act_present;
        r.write_target = act_present && act_slot == 1'b0;
        r.write_generation = act_present ? act_gen + 32'd1 : 32'd1;
        expected_results.push_back(r);
    endtask

    function automatic t_in mk(logic [1:0] c, logic s, logic [7:0] b, logic l);
        t_in t;
        t.cmd = c;
        t.slot = s;
        t.data_byte = b;
        t.last = l;
        return t;
    endfunction

    // builds a slot image; corrupt selects a fault (1 flips a random bit, 2 truncates), extra adds trailing bytes
    task automatic queue_image(logic s, logic [15:0] len, logic [31:0] gen, int corrupt,
                               int extra);
        logic [7:0] img [$];
        logic [31:0] c;
        int pos;
        img = {"O", "H", "C", "S", 8'd1, 8'd0, len[7:0], len[15:8],
               gen[7:0], gen[15:8], gen[23:16], gen[31:24]};
        for (int i = 0; i < len; i++) img.push_back(8'($urandom));
        c = 32'hffffffff;
        foreach (img[i]) c = crc_step(c, img[i]);
        c = ~c;
        img.push_back(c[7:0]);
        img.push_back(c[15:8]);
        img.push_back(c[23:16]);
        img.push_back(c[31:24]);
        for (int i = 0; i < extra; i++) img.push_back(8'($urandom));
        if (corrupt == 1) begin
            pos = $urandom_range(0, img.size() - 1);
            img[pos] = img[pos] ^ (8'd1 << $urandom_range(0, 7));
        end else if (corrupt == 2) begin
            pos = $urandom_range(1, img.size() - 1);
            while (img.size() > pos) void'(img.pop_back());
        end
        foreach (img[i]) pending_items.push_back(mk(CMD_BYTE, s, img[i], i == img.size() - 1));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_max_len(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        max_len = v;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                push <= 1'b1;
                i_in <= pending_items[0];
            end else begin
                push <= 1'b0;
            end
        end
        pop <= $urandom_range(0, 99) >= recv_stall_pct;
    end

    // monitor
    always @(posedge i_clk) begin
        t_out e;
        logic busy;
        if (i_rst_n) begin
            busy = 1'b0;
            in_taken <= push && !full;
            if (push && !full) begin
                predict_checker(pending_items.pop_front());
                busy = 1'b1;
            end
            if (pop && !empty) begin
                busy = 1'b1;
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result %p", $time, o_out);
                    errors <= errors + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (o_out !== e) begin
                        $display("%0t mismatch expected %p actual %p", $time, e, o_out);
                        errors <= errors + 1;
                    end
                end
            end
            idle_count <= busy ? 0 : idle_count + 1;
            if (idle_count >= WatchLimit) begin
                $display("watchdog expired at %0t", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        logic [15:0] len;
        errors = 0;
        results_seen = 0;
        idle_count = 0;
        in_taken = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        reset_checker_model();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        pending_items.push_back(mk(CMD_COMMIT, 1'b0, 8'h00, 1'b0));
        pending_items.push_back(mk(CMD_SELECT, 1'b0, 8'h00, 1'b0));
        pending_items.push_back(mk(CMD_COMMIT, 1'b1, 8'hff, 1'b1));
        pending_items.push_back(mk(CMD_FAIL, 1'b1, 8'hff, 1'b1));
        pending_items.push_back(mk(CMD_BYTE, 1'b0, 8'hff, 1'b1));
        pending_items.push_back(mk(CMD_BYTE, 1'b1, 8'h00, 1'b0));
        pending_items.push_back(mk(CMD_BYTE, 1'b1, 8'h00, 1'b1));
        pending_items.push_back(mk(CMD_SELECT, 1'b1, 8'haa, 1'b1));
        queue_image(1'b0, 16'd0, 32'hffffffff, 0, 0);
        queue_image(1'b1, 16'd1, 32'h7fffffff, 0, 2);
        pending_items.push_back(mk(CMD_SELECT, 1'b0, 8'h00, 1'b0));
        pending_items.push_back(mk(CMD_COMMIT, 1'b0, 8'h00, 1'b0));
        wait_drained();
        write_max_len(8'd0);
        queue_image(1'b1, 16'd3, 32'h5, 0, 0);
        queue_image(1'b0, 16'd0, 32'h80000000, 0, 0);
        pending_items.push_back(mk(CMD_SELECT, 1'b0, 8'h00, 1'b0));
        wait_drained();
        write_max_len(8'd255);
        queue_image(1'b0, 16'd240, 32'h1, 0, 0);
        queue_image(1'b1, 16'd241, 32'h2, 0, 0);
        pending_items.push_back(mk(CMD_SELECT, 1'b0, 8'h00, 1'b0));
        wait_drained();

        // random phases
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 52; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 52; end
                3: begin send_idle_pct = 30; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            write_max_len(ph == 4 ? 8'd240 : 8'($urandom_range(0, 255)));
            for (int n = 0; n < 110; ) begin
                mode = $urandom_range(0, 99);
                len = (mode < 5) ? 16'($urandom_range(0, 240)) : 16'($urandom_range(0, 12));
                if (mode < 60) begin
                    queue_image(1'($urandom_range(0, 1)), len, $urandom,
                                $urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0,
                                $urandom_range(0, 3) == 0 ? 2 : 0);
                    n += 20 + len;
                end else if (mode < 72) begin
                    pending_items.push_back(mk(CMD_FAIL, 1'($urandom), 8'($urandom),
                                               1'($urandom)));
                    n++;
                end else if (mode < 85) begin
                    pending_items.push_back(mk(CMD_SELECT, 1'($urandom), 8'($urandom),
                                               1'($urandom)));
                    n++;
                end else if (mode < 95) begin
                    pending_items.push_back(mk(CMD_COMMIT, 1'($urandom), 8'($urandom),
                                               1'($urandom)));
                    n++;
                end else begin
                    pending_items.push_back(mk(CMD_BYTE, 1'($urandom), 8'($urandom),
                                               1'($urandom)));
                    n++;
                end
            end
            wait_drained();
        end

        $display("covered slot images, read failures, selects and commits under %0d results,",
                 results_seen);
        $display("several length limits and sender/receiver idle mixes");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
